/* rtl/core/osit_pkg.sv */
`default_nettype none

// Shared types and constants of the ordered integer hash map.
package osit_pkg;

	// Field widths of the command and result words.
	localparam int KEY_W   = 64;
	localparam int VALUE_W = 64;
	localparam int TYPE_W  = 8;
	localparam int INDEX_W = 8;
	localparam int COUNT_W = 9;
	localparam int LIMIT_W = 9;

	// Operation codes.
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_FIND    = 2'd0;
	localparam kind_t KIND_INSERT  = 2'd1;
	localparam kind_t KIND_POP     = 2'd2;
	localparam kind_t KIND_COMPACT = 2'd3;

	// Result status codes.
	typedef logic [1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_REFUSED   = 2'd2;
	localparam status_t ST_POP_EMPTY = 2'd3;

	// Control byte codes of the tag plane.
	localparam logic [7:0] TAG_EMPTY   = 8'h80;
	localparam logic [7:0] TAG_DELETED = 8'hFE;

	// Slots probed per group.
	localparam int GROUP_SIZE = 16;

	// Mixing constants of the 64-bit key hash.
	localparam logic [63:0] MIX_C1 = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_C2 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C3 = 64'h94d049bb133111eb;

endpackage

`default_nettype wire

/* rtl/core/osit_if.sv */
`default_nettype none

// Command word channel.
interface osit_cmd_if import osit_pkg::*; ();
	logic                      valid;
	logic                      ready;
	kind_t                     kind;
	logic signed [KEY_W-1:0]   key;
	logic [TYPE_W-1:0]         value_type;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, kind, key, value_type, value, input ready);
	modport sink   (input valid, kind, key, value_type, value, output ready);
endinterface

// Result word channel.
interface osit_res_if import osit_pkg::*; ();
	logic                      valid;
	logic                      ready;
	status_t                   status;
	logic [INDEX_W-1:0]        dense_index;
	logic [TYPE_W-1:0]         found_type;
	logic signed [VALUE_W-1:0] found_value;
	logic [COUNT_W-1:0]        element_count;

	modport source (output valid, status, dense_index, found_type, found_value,
		element_count, input ready);
	modport sink   (input valid, status, dense_index, found_type, found_value,
		element_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/osit_mix.sv */
`default_nettype none

// Iterative 64-bit key mixer. One 32x32 multiplier is reused for the three
// partial products of each 64-bit multiply.
module osit_mix import osit_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] din,
	output logic             done,
	output logic [63:0]      dout
);

	typedef enum logic [3:0] {
		MX_IDLE = 4'b0001,
		MX_XOR  = 4'b0010,
		MX_MUL  = 4'b0100,
		MX_FIN  = 4'b1000
	} mx_state_t;

	mx_state_t   st_q;
	logic        pass_q;
	logic [1:0]  ph_q;
	logic [63:0] z_q;
	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [63:0] p_q;
	logic [63:0] dout_q;
	logic        done_q;

	logic [63:0] mul_k;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [63:0] add_term;
	logic [63:0] acc_nx;

	// Operand selection for the shared multiplier: low x low, low x high, high x low.
	always_comb begin
		mul_k    = pass_q ? MIX_C3 : MIX_C2;
		mul_a    = (ph_q == 2'd2) ? a_q[63:32] : a_q[31:0];
		mul_b    = (ph_q == 2'd1) ? mul_k[63:32] : mul_k[31:0];
		prod     = 64'(mul_a) * 64'(mul_b);
		add_term = (ph_q >= 2'd2) ? {p_q[31:0], 32'd0} : p_q;
		acc_nx   = acc_q + add_term;
	end

	// Sequencer of the two xor-shift and multiply rounds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= MX_IDLE;
			pass_q <= 1'b0;
			ph_q   <= 2'd0;
			z_q    <= '0;
			a_q    <= '0;
			acc_q  <= '0;
			p_q    <= '0;
			dout_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == MX_FIN);
			case (st_q)
				MX_IDLE: begin
					if (start) begin
						z_q    <= din + MIX_C1;
						pass_q <= 1'b0;
						st_q   <= MX_XOR;
					end
				end
				MX_XOR: begin
					a_q   <= pass_q ? (z_q ^ (z_q >> 27)) : (z_q ^ (z_q >> 30));
					acc_q <= '0;
					ph_q  <= 2'd0;
					st_q  <= MX_MUL;
				end
				MX_MUL: begin
					if (ph_q != 2'd3) begin
						p_q <= prod;
					end
					if (ph_q != 2'd0) begin
						acc_q <= acc_nx;
					end
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						z_q <= acc_nx;
						if (pass_q) begin
							st_q <= MX_FIN;
						end else begin
							pass_q <= 1'b1;
							st_q   <= MX_XOR;
						end
					end
				end
				MX_FIN: begin
					dout_q <= z_q ^ (z_q >> 31);
					st_q   <= MX_IDLE;
				end
				default: begin
					st_q <= MX_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign dout = dout_q;

endmodule

`default_nettype wire

/* rtl/core/ordered_swiss_int_table.sv */
`default_nettype none

// Insertion-ordered hash map on 64-bit integer keys, one command word at a time.
// Find, insert-or-update, pop-last and compact each give one result word. After
// reset the tag plane is swept to EMPTY, one slot a cycle, before the first
// command word is taken. In hashed mode a find or insert first runs the key
// mixer, then probes the tag plane slot by slot, with a stored-key compare for
// each tag hit; a probe normally ends inside its first group of sixteen slots.
// A pop in hashed mode probes for its slot in the same way. A rebuild (on the
// switch to hashed mode, or a compact with tombstones present) sweeps the tag
// plane, then rehashes and re-probes each live entry. A result word is held in
// an output register, so the next command word is taken while it waits.
module ordered_swiss_int_table import osit_pkg::*; #(
	parameter int SLOT_COUNT  = 256,
	parameter int DENSE_DEPTH = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata,
	osit_cmd_if.sink                cmd,
	osit_res_if.source              res
);

	localparam int SW = $clog2(SLOT_COUNT);
	localparam int DW = (DENSE_DEPTH > 1) ? $clog2(DENSE_DEPTH) : 1;
	localparam int CW = $clog2(DENSE_DEPTH + 1);
	localparam int TW = $clog2(SLOT_COUNT + 1);
	localparam bit SLOT_POW2 = ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0);
	localparam logic [31:0] LOAD_LIM = 32'(SLOT_COUNT * 7);

	typedef enum logic [15:0] {
		S_CLR     = 16'h0001,
		S_IDLE    = 16'h0002,
		S_ENT_RD  = 16'h0004,
		S_ENT_OK  = 16'h0008,
		S_HASH    = 16'h0010,
		S_PR_A    = 16'h0020,
		S_PR_B    = 16'h0040,
		S_PR_C    = 16'h0080,
		S_PR_END  = 16'h0100,
		S_NEW     = 16'h0200,
		S_APP     = 16'h0400,
		S_RB_RD   = 16'h0800,
		S_RB_HS   = 16'h1000,
		S_RB_WT   = 16'h2000,
		S_POP_RD  = 16'h4000,
		S_DONE    = 16'h8000
	} st_t;

	typedef enum logic [2:0] {
		PM_KEY   = 3'b001,
		PM_DENSE = 3'b010,
		PM_FREE  = 3'b100
	} pmode_t;

	typedef struct packed {
		status_t           st;
		logic [DW-1:0]     d;
		logic [TYPE_W-1:0] t;
		logic [63:0]       v;
	} result_t;

	function automatic result_t mk_res(status_t s, logic [DW-1:0] d,
		logic [TYPE_W-1:0] t, logic [63:0] v);
		result_t r;
		r.st = s;
		r.d  = d;
		r.t  = t;
		r.v  = v;
		return r;
	endfunction

	// Stores.
	logic [7:0]        tag_mem [SLOT_COUNT];
	logic [DW-1:0]     s2d_mem [SLOT_COUNT];
	logic [63:0]       key_mem [DENSE_DEPTH];
	logic [63:0]       val_mem [DENSE_DEPTH];
	logic [TYPE_W-1:0] typ_mem [DENSE_DEPTH];
	logic [63:0]       hsh_mem [DENSE_DEPTH];

	logic [7:0]        tag_rd;
	logic [DW-1:0]     s2d_rd;
	logic [63:0]       key_rd;
	logic [63:0]       val_rd;
	logic [TYPE_W-1:0] typ_rd;
	logic [63:0]       hsh_rd;

	// Control and working registers.
	st_t               st_q;
	pmode_t            mode_q;
	kind_t             kind_q;
	logic [63:0]       key_q;
	logic [TYPE_W-1:0] vtype_q;
	logic [63:0]       val_q;
	logic [CW-1:0]     used_q;
	logic [TW-1:0]     tomb_q;
	logic              packed_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [63:0]       hash_q;
	logic [DW-1:0]     d_q;
	logic [SW-1:0]     slot_q;
	logic [SW-1:0]     grp_q;
	logic [SW:0]       step_q;
	logic [3:0]        idx_q;
	logic              emp_q;
	logic              hit_q;
	logic              fdel_q;
	logic              rb_q;
	logic              newp_q;
	logic [CW-1:0]     ri_q;
	logic [SW-1:0]     clr_q;
	result_t           res_q;
	result_t           out_q;
	logic [COUNT_W-1:0] out_cnt_q;
	logic              out_vld_q;

	// Combinational helpers.
	logic              mix_start;
	logic [63:0]       mix_din;
	logic              mix_done;
	logic [63:0]       mix_dout;
	logic [SW-1:0]     slot_a;
	logic [DW-1:0]     used_a;
	logic [DW-1:0]     key_ra;
	logic [31:0]       cap;
	logic              full;
	logic [31:0]       occ;
	logic              load_ok;
	logic              pk_hit;
	logic              pk_next;
	logic              cur_emp;
	logic              tmatch;
	logic              adv_e;
	logic [SW:0]       stepn;
	logic              adv_miss;
	logic              rb_done;
	logic              claim;
	logic              app_we;
	logic              upd_we;
	logic              tag_we;
	logic [SW-1:0]     tag_wa;
	logic [7:0]        tag_wd;
	logic              vt_we;
	logic [DW-1:0]     vt_wa;
	logic              hsh_we;
	logic [DW-1:0]     hsh_wa;
	logic [63:0]       hsh_wd;
	logic              out_load;

	osit_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mix_start),
		.din    (mix_din),
		.done   (mix_done),
		.dout   (mix_dout)
	);

	// Capacity, load and packed-mode key checks.
	always_comb begin
		used_a  = used_q[DW-1:0];
		cap     = (32'(limit_q) < 32'(DENSE_DEPTH)) ? 32'(limit_q) : 32'(DENSE_DEPTH);
		full    = 32'(used_q) >= cap;
		occ     = 32'(used_q) + 32'(tomb_q) + 32'd1;
		load_ok = (occ << 3) < LOAD_LIM;
		pk_hit  = !cmd.key[63] && ($unsigned(cmd.key) < 64'(used_q));
		pk_next = $unsigned(cmd.key) == 64'(used_q);
		rb_done = (st_q == S_RB_RD) && (32'(ri_q) >= 32'(used_q));
	end

	// Probe walker: slot address, tag tests and group stepping.
	always_comb begin
		slot_a   = grp_q + SW'(idx_q);
		cur_emp  = tag_rd == TAG_EMPTY;
		tmatch   = tag_rd == {1'b0, hash_q[6:0]};
		adv_e    = (st_q == S_PR_B) ? (emp_q | cur_emp) : emp_q;
		stepn    = step_q + (SW + 1)'(GROUP_SIZE);
		adv_miss = (idx_q == 4'hF) &&
			(((mode_q != PM_FREE) && adv_e) || (stepn == (SW + 1)'(SLOT_COUNT)));
		key_ra   = (st_q == S_PR_B) ? s2d_rd : ri_q[DW-1:0];
	end

	// Mixer start and operand.
	always_comb begin
		mix_start = ((st_q == S_IDLE) && cmd.valid && !packed_q &&
			(((cmd.kind == KIND_FIND) && (used_q != '0)) ||
			((cmd.kind == KIND_INSERT) && (cmd.value_type != '0)))) ||
			(rb_done && (kind_q == KIND_INSERT)) || (st_q == S_RB_HS);
		if (st_q == S_RB_HS) begin
			mix_din = key_rd;
		end else if (st_q == S_IDLE) begin
			mix_din = $unsigned(cmd.key);
		end else begin
			mix_din = key_q;
		end
	end

	// Store write controls.
	always_comb begin
		claim  = (st_q == S_PR_END) && (mode_q == PM_FREE) && hit_q &&
			(rb_q || fdel_q || load_ok);
		app_we = (st_q == S_APP) || (claim && !rb_q);
		upd_we = (st_q == S_PR_END) && (mode_q == PM_KEY) && hit_q &&
			(kind_q == KIND_INSERT);
		tag_we = (st_q == S_CLR) || claim ||
			((st_q == S_PR_END) && (mode_q == PM_DENSE) && hit_q);
		tag_wa = (st_q == S_CLR) ? clr_q : slot_q;
		if (st_q == S_CLR) begin
			tag_wd = TAG_EMPTY;
		end else if (mode_q == PM_DENSE) begin
			tag_wd = TAG_DELETED;
		end else begin
			tag_wd = {1'b0, hash_q[6:0]};
		end
		vt_we  = app_we || upd_we;
		vt_wa  = app_we ? used_a : d_q;
		hsh_we = app_we || ((st_q == S_RB_WT) && mix_done);
		hsh_wa = app_we ? used_a : ri_q[DW-1:0];
		hsh_wd = app_we ? (packed_q ? 64'd0 : hash_q) : mix_dout;
	end

	// Tag plane and slot-to-entry map.
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		if (claim) begin
			s2d_mem[slot_q] <= rb_q ? ri_q[DW-1:0] : used_a;
		end
		tag_rd <= tag_mem[slot_a];
		s2d_rd <= s2d_mem[slot_a];
	end

	// Dense entry store.
	always_ff @(posedge clk) begin
		if (app_we) begin
			key_mem[used_a] <= key_q;
		end
		if (vt_we) begin
			val_mem[vt_wa] <= val_q;
			typ_mem[vt_wa] <= vtype_q;
		end
		if (hsh_we) begin
			hsh_mem[hsh_wa] <= hsh_wd;
		end
		key_rd <= key_mem[key_ra];
		val_rd <= val_mem[d_q];
		typ_rd <= typ_mem[d_q];
		hsh_rd <= hsh_mem[d_q];
	end

	assign out_load = (st_q == S_DONE) && (!out_vld_q || res.ready);

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_CLR;
			mode_q    <= PM_KEY;
			kind_q    <= KIND_FIND;
			key_q     <= '0;
			vtype_q   <= '0;
			val_q     <= '0;
			used_q    <= '0;
			tomb_q    <= '0;
			packed_q  <= 1'b1;
			limit_q   <= LIMIT_W'(256);
			hash_q    <= '0;
			d_q       <= '0;
			slot_q    <= '0;
			grp_q     <= '0;
			step_q    <= '0;
			idx_q     <= '0;
			emp_q     <= 1'b0;
			hit_q     <= 1'b0;
			fdel_q    <= 1'b0;
			rb_q      <= 1'b0;
			newp_q    <= 1'b0;
			ri_q      <= '0;
			clr_q     <= '0;
			res_q     <= '0;
			out_q     <= '0;
			out_cnt_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			// The output register fills from S_DONE and empties when the word is taken.
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && res.ready) begin
				out_vld_q <= 1'b0;
			end

			case (st_q)
				// Sweep the tag plane to EMPTY after reset and before a rebuild.
				S_CLR: begin
					if (clr_q == SW'(SLOT_COUNT - 1)) begin
						clr_q <= '0;
						ri_q  <= '0;
						st_q  <= rb_q ? S_RB_RD : S_IDLE;
					end else begin
						clr_q <= clr_q + SW'(1);
					end
				end

				// Take a command word and dispatch it.
				S_IDLE: begin
					if (cmd.valid) begin
						kind_q  <= cmd.kind;
						key_q   <= $unsigned(cmd.key);
						vtype_q <= cmd.value_type;
						val_q   <= $unsigned(cmd.value);
						newp_q  <= 1'b0;
						case (cmd.kind)
							KIND_FIND: begin
								if (used_q == '0) begin
									res_q <= mk_res(ST_NOT_FOUND, '0, '0, '0);
									st_q  <= S_DONE;
								end else if (packed_q) begin
									if (pk_hit) begin
										d_q    <= cmd.key[DW-1:0];
										mode_q <= PM_KEY;
										hit_q  <= 1'b1;
										st_q   <= S_PR_END;
									end else begin
										res_q <= mk_res(ST_NOT_FOUND, '0, '0, '0);
										st_q  <= S_DONE;
									end
								end else begin
									st_q <= S_HASH;
								end
							end
							KIND_INSERT: begin
								if (cmd.value_type == '0) begin
									res_q <= mk_res(ST_REFUSED, '0, '0, '0);
									st_q  <= S_DONE;
								end else if (!packed_q) begin
									st_q <= S_HASH;
								end else if (pk_hit) begin
									d_q    <= cmd.key[DW-1:0];
									mode_q <= PM_KEY;
									hit_q  <= 1'b1;
									st_q   <= S_PR_END;
								end else if (pk_next) begin
									if (full) begin
										res_q <= mk_res(ST_REFUSED, '0, '0, '0);
										st_q  <= S_DONE;
									end else begin
										st_q <= S_APP;
									end
								end else if (!SLOT_POW2) begin
									res_q <= mk_res(ST_REFUSED, '0, '0, '0);
									st_q  <= S_DONE;
								end else begin
									// Out-of-sequence key: leave packed mode and rebuild.
									packed_q <= 1'b0;
									tomb_q   <= '0;
									rb_q     <= 1'b1;
									clr_q    <= '0;
									st_q     <= S_CLR;
								end
							end
							KIND_POP: begin
								if (used_q == '0) begin
									res_q <= mk_res(ST_POP_EMPTY, '0, '0, '0);
									st_q  <= S_DONE;
								end else begin
									d_q  <= DW'(used_q - CW'(1));
									st_q <= S_POP_RD;
								end
							end
							default: begin
								if (tomb_q == '0 || packed_q) begin
									tomb_q <= '0;
									res_q  <= mk_res(ST_OK, '0, '0, '0);
									st_q   <= S_DONE;
								end else begin
									tomb_q <= '0;
									rb_q   <= 1'b1;
									clr_q  <= '0;
									st_q   <= S_CLR;
								end
							end
						endcase
					end
				end

				// Read back a found entry, or the last entry for a pop.
				S_ENT_RD: begin
					st_q <= S_ENT_OK;
				end
				S_ENT_OK: begin
					res_q <= mk_res(ST_OK, d_q, typ_rd, val_rd);
					if (kind_q != KIND_POP) begin
						st_q <= S_DONE;
					end else if (packed_q) begin
						// Packed pop: the last entry drops off the end.
						used_q <= used_q - CW'(1);
						st_q   <= S_DONE;
					end else begin
						// Hashed pop: find the entry's slot so that it can be marked DELETED.
						hash_q <= hsh_rd;
						grp_q  <= hsh_rd[7 +: SW];
						step_q <= '0;
						idx_q  <= '0;
						emp_q  <= 1'b0;
						mode_q <= PM_DENSE;
						st_q   <= S_PR_A;
					end
				end

				// Wait for the key hash, then probe by key or go on to append.
				S_HASH: begin
					if (mix_done) begin
						hash_q <= mix_dout;
						if (newp_q || used_q == '0) begin
							if (kind_q == KIND_FIND) begin
								res_q <= mk_res(ST_NOT_FOUND, '0, '0, '0);
								st_q  <= S_DONE;
							end else begin
								st_q <= S_NEW;
							end
						end else begin
							grp_q  <= mix_dout[7 +: SW];
							step_q <= '0;
							idx_q  <= '0;
							emp_q  <= 1'b0;
							mode_q <= PM_KEY;
							st_q   <= S_PR_A;
						end
					end
				end

				// Probe: tag and map read issued.
				S_PR_A: begin
					st_q <= S_PR_B;
				end

				// Probe: test the slot.
				S_PR_B: begin
					if ((mode_q == PM_FREE) && (cur_emp || tag_rd == TAG_DELETED)) begin
						slot_q <= slot_a;
						fdel_q <= tag_rd == TAG_DELETED;
						hit_q  <= 1'b1;
						st_q   <= S_PR_END;
					end else if ((mode_q == PM_DENSE) && tmatch && (s2d_rd == d_q)) begin
						slot_q <= slot_a;
						hit_q  <= 1'b1;
						st_q   <= S_PR_END;
					end else if ((mode_q == PM_KEY) && tmatch &&
						(32'(s2d_rd) < 32'(used_q))) begin
						d_q    <= s2d_rd;
						slot_q <= slot_a;
						st_q   <= S_PR_C;
					end else if (adv_miss) begin
						hit_q <= 1'b0;
						st_q  <= S_PR_END;
					end else begin
						st_q <= S_PR_A;
						if (idx_q == 4'hF) begin
							idx_q  <= '0;
							step_q <= stepn;
							grp_q  <= grp_q + stepn[SW-1:0];
							emp_q  <= 1'b0;
						end else begin
							idx_q <= idx_q + 4'd1;
							emp_q <= adv_e;
						end
					end
				end

				// Probe: compare the stored key of a tag hit.
				S_PR_C: begin
					if (key_rd == key_q) begin
						hit_q <= 1'b1;
						st_q  <= S_PR_END;
					end else if (adv_miss) begin
						hit_q <= 1'b0;
						st_q  <= S_PR_END;
					end else begin
						st_q <= S_PR_A;
						if (idx_q == 4'hF) begin
							idx_q  <= '0;
							step_q <= stepn;
							grp_q  <= grp_q + stepn[SW-1:0];
							emp_q  <= 1'b0;
						end else begin
							idx_q <= idx_q + 4'd1;
						end
					end
				end

				// Act on the probe outcome.
				S_PR_END: begin
					case (mode_q)
						PM_KEY: begin
							if (hit_q) begin
								if (kind_q == KIND_FIND) begin
									st_q <= S_ENT_RD;
								end else begin
									res_q <= mk_res(ST_OK, d_q, vtype_q, val_q);
									st_q  <= S_DONE;
								end
							end else if (kind_q == KIND_FIND) begin
								res_q <= mk_res(ST_NOT_FOUND, '0, '0, '0);
								st_q  <= S_DONE;
							end else begin
								st_q <= S_NEW;
							end
						end
						PM_DENSE: begin
							if (hit_q) begin
								tomb_q <= tomb_q + TW'(1);
							end
							used_q <= used_q - CW'(1);
							res_q  <= mk_res(ST_OK, d_q, res_q.t, res_q.v);
							st_q   <= S_DONE;
						end
						default: begin
							if (rb_q) begin
								ri_q <= ri_q + CW'(1);
								st_q <= S_RB_RD;
							end else if (claim) begin
								if (fdel_q && tomb_q != '0) begin
									tomb_q <= tomb_q - TW'(1);
								end
								used_q <= used_q + CW'(1);
								res_q  <= mk_res(ST_OK, used_a, vtype_q, val_q);
								st_q   <= S_DONE;
							end else begin
								res_q <= mk_res(ST_REFUSED, '0, '0, '0);
								st_q  <= S_DONE;
							end
						end
					endcase
				end

				// New key in hashed mode: look for a free slot.
				S_NEW: begin
					if (full) begin
						res_q <= mk_res(ST_REFUSED, '0, '0, '0);
						st_q  <= S_DONE;
					end else begin
						grp_q  <= hash_q[7 +: SW];
						step_q <= '0;
						idx_q  <= '0;
						emp_q  <= 1'b0;
						mode_q <= PM_FREE;
						st_q   <= S_PR_A;
					end
				end

				// Append the next dense key in packed mode.
				S_APP: begin
					used_q <= used_q + CW'(1);
					res_q  <= mk_res(ST_OK, used_a, vtype_q, val_q);
					st_q   <= S_DONE;
				end

				// Rebuild: walk the dense store and re-place every entry.
				S_RB_RD: begin
					if (rb_done) begin
						rb_q <= 1'b0;
						if (kind_q == KIND_INSERT) begin
							newp_q <= 1'b1;
							st_q   <= S_HASH;
						end else begin
							res_q <= mk_res(ST_OK, '0, '0, '0);
							st_q  <= S_DONE;
						end
					end else begin
						st_q <= S_RB_HS;
					end
				end
				S_RB_HS: begin
					st_q <= S_RB_WT;
				end
				S_RB_WT: begin
					if (mix_done) begin
						hash_q <= mix_dout;
						grp_q  <= mix_dout[7 +: SW];
						step_q <= '0;
						idx_q  <= '0;
						emp_q  <= 1'b0;
						mode_q <= PM_FREE;
						st_q   <= S_PR_A;
					end
				end

				// Pop: read the last entry, then clear its slot in hashed mode.
				S_POP_RD: begin
					st_q <= S_ENT_RD;
				end

				// Hand the result word to the output register.
				S_DONE: begin
					if (out_load) begin
						out_q     <= res_q;
						out_cnt_q <= COUNT_W'(used_q);
						st_q      <= S_IDLE;
					end
				end

				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready         = (st_q == S_IDLE);
	assign res.valid         = out_vld_q;
	assign res.status        = out_q.st;
	assign res.dense_index   = INDEX_W'(out_q.d);
	assign res.found_type    = out_q.t;
	assign res.found_value   = $signed(out_q.v);
	assign res.element_count = out_cnt_q;

endmodule

`default_nettype wire
